@@ rtl/core/abgseg_pkg.sv @@
`default_nettype none
package abgseg_pkg;

  localparam int CH_W       = 8;
  localparam int SUM_W      = 18;
  localparam int TH_W       = 24;
  localparam int SCALE_W    = 8;
  localparam int SCALE_FRAC = 4;
  localparam int IDX_W      = 16;
  localparam int MASK_W     = 8;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int LANES      = 3;

  localparam logic [MASK_W-1:0] MASK_FG = 8'hFF;
  localparam logic [MASK_W-1:0] MASK_BG = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HI_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_SCALE   = 2'd2;

  localparam logic [CFG_W-1:0]   PIXEL_COUNT_RST = 17'd65536;
  localparam logic [SCALE_W-1:0] HI_SCALE_RST    = 8'd112;
  localparam logic [SCALE_W-1:0] LOW_SCALE_RST   = 8'd96;

  typedef enum logic [1:0] {
    FUNC_LEARN   = 2'd0,
    FUNC_BUILD   = 2'd1,
    FUNC_SEGMENT = 2'd2
  } func_e;

  // per-item commands to every channel lane
  typedef struct packed {
    logic learn;
    logic build;
    logic seg;
    logic add;
    logic clear;
  } lane_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/average_background_segmenter.sv @@
// averaging background subtractor, three channels per pixel
// items come in on the in_valid_i / in_ready_o channel: func_i selects learn,
// build or segment, pixel_index_i the pixel, chan_a/b/c_i the samples
// every item gives exactly one result on out_valid_o / out_ready_i:
// mask_o (255 foreground, 0 background) and mask_valid_o (segment items only)
// one lane per channel holds that channel's stores; the merge stage ORs them
// the pipeline runs through the read stage, the bit-per-stage frame-count
// dividers of the build path and the scale stage into the output register
// throughput: one item per cycle unless the receiver stalls; an item whose
// pixel index is still in flight waits until the earlier item leaves the
// pipeline (read-modify-write order)
// configuration via cfg_we_i / cfg_idx_i / cfg_data_i, written while idle
// after reset the sum stores are cleared one pixel per cycle, all MAX_PIXELS
// of them, and no item is taken until that pass ends
// when the receiver stalls, the whole pipeline holds and in_ready_o drops
// once the output register is full
`default_nettype none
module average_background_segmenter #(
  parameter int MAX_PIXELS = 65536,
  parameter int MAX_FRAMES = 1024,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [1:0]                           func_i,
  input  wire logic [abgseg_pkg::IDX_W-1:0]         pixel_index_i,
  input  wire logic [abgseg_pkg::CH_W-1:0]          chan_a_i,
  input  wire logic [abgseg_pkg::CH_W-1:0]          chan_b_i,
  input  wire logic [abgseg_pkg::CH_W-1:0]          chan_c_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [abgseg_pkg::MASK_W-1:0]             mask_o,
  output logic                                      mask_valid_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [abgseg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [abgseg_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW0   = $clog2(MAX_PIXELS + 1);
  localparam int CNT_W = ((CW0 > abgseg_pkg::CFG_W) ? CW0 : abgseg_pkg::CFG_W) + 1;
  localparam int FRM_W = $clog2(MAX_FRAMES + 1);
  localparam int LAT   = abgseg_pkg::SUM_W + FRAC_BITS + 2;
  localparam int SW    = abgseg_pkg::SCALE_W;

  // configuration registers
  logic [abgseg_pkg::CFG_W-1:0] pixel_count_q;
  logic [SW-1:0]                hi_scale_q, low_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= abgseg_pkg::PIXEL_COUNT_RST;
      hi_scale_q    <= abgseg_pkg::HI_SCALE_RST;
      low_scale_q   <= abgseg_pkg::LOW_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        abgseg_pkg::CFG_PIXEL_COUNT: pixel_count_q <= cfg_data_i;
        abgseg_pkg::CFG_HI_SCALE:    hi_scale_q    <= cfg_data_i[SW-1:0];
        abgseg_pkg::CFG_LOW_SCALE:   low_scale_q   <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass over the sum stores
  logic             clr_q;
  logic [PIX_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + PIX_W'(1);
      if (clr_addr_q == PIX_W'(MAX_PIXELS - 1)) clr_q <= 1'b0;
    end
  end

  // in-flight tracking
  logic             vld_q  [LAT];
  logic [1:0]       func_q [LAT];
  logic             ok_q   [LAT];
  logic [PIX_W-1:0] idx_q  [LAT];
  logic             out_valid_q;
  logic             en;
  logic             accept;

  logic [CNT_W-1:0] idx_ext, eff_m1;
  logic             ok, hit, frame_end;

  assign en      = !out_valid_q || out_ready_i;
  assign idx_ext = CNT_W'(pixel_index_i);
  assign ok      = idx_ext < CNT_W'(MAX_PIXELS);

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < LAT; k++) begin
      if (vld_q[k] && ok_q[k] && ok && (idx_q[k] == idx_ext[PIX_W-1:0])) hit = 1'b1;
    end
  end

  assign in_ready_o = en && !clr_q && !hit;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (pixel_count_q == '0) begin
      eff_m1 = '0;
    end else if (CNT_W'(pixel_count_q) > CNT_W'(MAX_PIXELS)) begin
      eff_m1 = CNT_W'(MAX_PIXELS - 1);
    end else begin
      eff_m1 = CNT_W'(pixel_count_q) - CNT_W'(1);
    end
    frame_end = (idx_ext == eff_m1);
  end

  // frame counting, done as the learn item is taken
  logic [FRM_W-1:0] frames_q;
  logic             seen_q;
  logic             add_en;
  logic             learn_ok;

  assign add_en   = seen_q && (frames_q < FRM_W'(MAX_FRAMES));
  assign learn_ok = accept && ok && (func_i == abgseg_pkg::FUNC_LEARN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
      seen_q   <= 1'b0;
    end else if (learn_ok && frame_end) begin
      if (!seen_q) seen_q <= 1'b1;
      else if (add_en) frames_q <= frames_q + FRM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= accept;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func_q[0] <= func_i;
      ok_q[0]   <= ok;
      idx_q[0]  <= idx_ext[PIX_W-1:0];
      for (int k = 1; k < LAT; k++) begin
        func_q[k] <= func_q[k-1];
        ok_q[k]   <= ok_q[k-1];
        idx_q[k]  <= idx_q[k-1];
      end
    end
  end

  // lanes
  abgseg_pkg::lane_ctl_t lane_ctl;
  logic [PIX_W-1:0]      lane_addr;
  logic [FRM_W-1:0]      n_eff;
  logic [abgseg_pkg::CH_W-1:0] chan [abgseg_pkg::LANES];
  logic [abgseg_pkg::LANES-1:0] in_range;

  always_comb begin
    lane_ctl.learn = learn_ok;
    lane_ctl.build = accept && ok && (func_i == abgseg_pkg::FUNC_BUILD);
    lane_ctl.seg   = accept && ok && (func_i == abgseg_pkg::FUNC_SEGMENT);
    lane_ctl.add   = add_en;
    lane_ctl.clear = clr_q;
    lane_addr      = clr_q ? clr_addr_q : idx_ext[PIX_W-1:0];
    n_eff          = (frames_q == '0) ? FRM_W'(1) : frames_q;
    chan[0]        = chan_a_i;
    chan[1]        = chan_b_i;
    chan[2]        = chan_c_i;
  end

  for (genvar l = 0; l < abgseg_pkg::LANES; l++) begin : g_lane
    abgseg_lane #(
      .MAX_PIXELS (MAX_PIXELS),
      .FRAC_BITS  (FRAC_BITS),
      .FRM_W      (FRM_W),
      .PIX_W      (PIX_W)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .ctl_i       (lane_ctl),
      .addr_i      (lane_addr),
      .chan_i      (chan[l]),
      .frames_i    (n_eff),
      .hi_scale_i  (hi_scale_q),
      .low_scale_i (low_scale_q),
      .in_range_o  (in_range[l])
    );
  end

  // merge and output register
  logic                          res_valid;
  logic [abgseg_pkg::MASK_W-1:0] res_mask;
  logic                          res_mask_valid;
  logic [abgseg_pkg::MASK_W-1:0] mask_q;
  logic                          mask_valid_q;

  abgseg_merge u_merge (
    .valid_i        (vld_q[LAT-1]),
    .func_i         (func_q[LAT-1]),
    .ok_i           (ok_q[LAT-1]),
    .in_range_i     (in_range),
    .result_valid_o (res_valid),
    .mask_o         (res_mask),
    .mask_valid_o   (res_mask_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mask_q       <= res_mask;
      mask_valid_q <= res_mask_valid;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mask_o       = mask_q;
  assign mask_valid_o = mask_valid_q;

  // no item enters during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && clr_q))
    else $error("item taken during clear pass");

  // frame count never passes its ceiling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q <= FRM_W'(MAX_FRAMES))
    else $error("frame count overflow");

  // frames are only counted after the first frame has been seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frames_q != $past(frames_q)) |-> $past(seen_q))
    else $error("frame counted before first frame");

  // an item leaving the pipeline lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-1] && en) |=> out_valid_q)
    else $error("result lost at output");

endmodule
`default_nettype wire

@@ rtl/core/abgseg_div.sv @@
`default_nettype none
module abgseg_div #(
  parameter int DVD_W = 26,
  parameter int DEN_W = 11
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic      [DVD_W-1:0] quotient_o
);

  // one quotient bit per stage, restoring
  logic [DEN_W-1:0] rem_q [DVD_W];
  logic [DVD_W-1:0] acc_q [DVD_W];
  logic [DEN_W-1:0] den_q [DVD_W];

  for (genvar s = 0; s < DVD_W; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DVD_W-1:0] acc_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign acc_in = dividend_i;
      assign den_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign acc_in = acc_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign trial = {rem_in, acc_in[DVD_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        acc_q[s] <= {acc_in[DVD_W-2:0], ge};
        den_q[s] <= den_in;
      end
    end
  end

  assign quotient_o = acc_q[DVD_W-1];

endmodule
`default_nettype wire

@@ rtl/core/abgseg_lane.sv @@
`default_nettype none
module abgseg_lane #(
  parameter int MAX_PIXELS = 65536,
  parameter int FRAC_BITS  = 8,
  parameter int FRM_W      = 11,
  parameter int PIX_W      = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire abgseg_pkg::lane_ctl_t              ctl_i,
  input  wire logic [PIX_W-1:0]                   addr_i,
  input  wire logic [abgseg_pkg::CH_W-1:0]        chan_i,
  input  wire logic [FRM_W-1:0]                   frames_i,
  input  wire logic [abgseg_pkg::SCALE_W-1:0]     hi_scale_i,
  input  wire logic [abgseg_pkg::SCALE_W-1:0]     low_scale_i,
  output logic                                    in_range_o
);

  localparam int CH_W    = abgseg_pkg::CH_W;
  localparam int SUM_W   = abgseg_pkg::SUM_W;
  localparam int TH_W    = abgseg_pkg::TH_W;
  localparam int DVD_W   = SUM_W + FRAC_BITS;
  localparam int DIFF_W  = DVD_W + 1;
  localparam int PROD_W  = abgseg_pkg::SCALE_W + DIFF_W;
  localparam int OFS_W   = PROD_W - abgseg_pkg::SCALE_FRAC;
  localparam int SUMH_W  = OFS_W + 2;
  localparam int XW      = CH_W + FRAC_BITS + 1;
  localparam int CMP_W   = ((TH_W > XW) ? TH_W : XW) + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic signed [SUMH_W-1:0] TH_MAX = SUMH_W'((64'sd1 <<< (TH_W - 1)) - 64'sd1);
  localparam logic signed [SUMH_W-1:0] TH_MIN = SUMH_W'(-(64'sd1 <<< (TH_W - 1)));

  logic [SUM_W-1:0] sum_mem  [MAX_PIXELS];
  logic [SUM_W-1:0] diff_mem [MAX_PIXELS];
  logic [CH_W-1:0]  prev_mem [MAX_PIXELS];
  logic [TH_W-1:0]  high_mem [MAX_PIXELS];
  logic [TH_W-1:0]  low_mem  [MAX_PIXELS];

  logic [SUM_W-1:0] sum_rd_q, diff_rd_q;
  logic [CH_W-1:0]  prev_rd_q;
  logic [TH_W-1:0]  high_rd_q, low_rd_q;

  logic             s1_learn_q, s1_build_q, s1_seg_q, s1_add_q;
  logic [PIX_W-1:0] s1_addr_q;
  logic [CH_W-1:0]  s1_ch_q;
  logic [FRM_W-1:0] s1_n_q;

  // registered reads, issued as the item is taken
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_rd_q  <= sum_mem[addr_i];
      diff_rd_q <= diff_mem[addr_i];
      prev_rd_q <= prev_mem[addr_i];
      high_rd_q <= high_mem[addr_i];
      low_rd_q  <= low_mem[addr_i];
      s1_addr_q <= addr_i;
      s1_ch_q   <= chan_i;
      s1_n_q    <= frames_i;
      s1_add_q  <= ctl_i.add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_learn_q <= 1'b0;
      s1_build_q <= 1'b0;
      s1_seg_q   <= 1'b0;
    end else if (en_i) begin
      s1_learn_q <= ctl_i.learn;
      s1_build_q <= ctl_i.build;
      s1_seg_q   <= ctl_i.seg;
    end
  end

  // learn: saturating accumulate
  logic [CH_W-1:0]  absd;
  logic [SUM_W:0]   sum_nx, diff_nx;
  logic             sd_we;
  logic [PIX_W-1:0] sd_addr;
  logic [SUM_W-1:0] sum_wd, diff_wd;

  always_comb begin
    absd    = (s1_ch_q >= prev_rd_q) ? s1_ch_q - prev_rd_q : prev_rd_q - s1_ch_q;
    sum_nx  = {1'b0, sum_rd_q} + (SUM_W + 1)'(s1_ch_q);
    diff_nx = {1'b0, diff_rd_q} + (SUM_W + 1)'(absd);
    sd_we   = ctl_i.clear || (en_i && s1_learn_q && s1_add_q);
    sd_addr = ctl_i.clear ? addr_i : s1_addr_q;
    if (ctl_i.clear) begin
      sum_wd  = '0;
      diff_wd = '0;
    end else begin
      sum_wd  = sum_nx[SUM_W]  ? SUM_MAX : sum_nx[SUM_W-1:0];
      diff_wd = diff_nx[SUM_W] ? SUM_MAX : diff_nx[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sd_we) begin
      sum_mem[sd_addr]  <= sum_wd;
      diff_mem[sd_addr] <= diff_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s1_learn_q) begin
      prev_mem[s1_addr_q] <= s1_ch_q;
    end
  end

  // segment: low <= x < high
  logic signed [CMP_W-1:0] x_s, lo_s, hi_s;
  logic                    ir_s1;

  always_comb begin
    x_s   = $signed(CMP_W'({s1_ch_q, {FRAC_BITS{1'b0}}}));
    lo_s  = $signed({{(CMP_W - TH_W){low_rd_q[TH_W-1]}}, low_rd_q});
    hi_s  = $signed({{(CMP_W - TH_W){high_rd_q[TH_W-1]}}, high_rd_q});
    ir_s1 = s1_seg_q && (lo_s <= x_s) && (x_s < hi_s);
  end

  // build: divide both sums by the frame count
  logic [FRM_W-1:0] n_div;
  logic [DVD_W-1:0] mean_div, dmean_div;

  assign n_div = s1_n_q;

  abgseg_div #(.DVD_W(DVD_W), .DEN_W(FRM_W)) u_div_sum (
    .clk_i      (clk_i),
    .en_i       (en_i),
    .dividend_i ({sum_rd_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (n_div),
    .quotient_o (mean_div)
  );

  abgseg_div #(.DVD_W(DVD_W), .DEN_W(FRM_W)) u_div_diff (
    .clk_i      (clk_i),
    .en_i       (en_i),
    .dividend_i ({diff_rd_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (n_div),
    .quotient_o (dmean_div)
  );

  logic             bv_q     [DVD_W];
  logic [PIX_W-1:0] addr_sh_q[DVD_W];
  logic             ir_sh_q  [DVD_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DVD_W; k++) bv_q[k] <= 1'b0;
      for (int k = 0; k <= DVD_W; k++) ir_sh_q[k] <= 1'b0;
    end else if (en_i) begin
      bv_q[0]    <= s1_build_q;
      ir_sh_q[0] <= ir_s1;
      for (int k = 1; k < DVD_W; k++) bv_q[k] <= bv_q[k-1];
      for (int k = 1; k <= DVD_W; k++) ir_sh_q[k] <= ir_sh_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr_sh_q[0] <= s1_addr_q;
      for (int k = 1; k < DVD_W; k++) addr_sh_q[k] <= addr_sh_q[k-1];
    end
  end

  // scale stage
  logic [DIFF_W-1:0] diffp;
  logic [PROD_W-1:0] up_full, dn_full;
  logic              m_bv_q;
  logic [PIX_W-1:0]  m_addr_q;
  logic [DVD_W-1:0]  m_mean_q;
  logic [OFS_W-1:0]  m_up_q, m_dn_q;

  always_comb begin
    diffp   = DIFF_W'(dmean_div) + (DIFF_W'(1) << FRAC_BITS);
    up_full = PROD_W'(hi_scale_i) * PROD_W'(diffp);
    dn_full = PROD_W'(low_scale_i) * PROD_W'(diffp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_bv_q <= 1'b0;
    end else if (en_i) begin
      m_bv_q <= bv_q[DVD_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_addr_q <= addr_sh_q[DVD_W-1];
      m_mean_q <= mean_div;
      m_up_q   <= up_full[PROD_W-1:abgseg_pkg::SCALE_FRAC];
      m_dn_q   <= dn_full[PROD_W-1:abgseg_pkg::SCALE_FRAC];
    end
  end

  // thresholds, saturated to the signed store width
  logic signed [SUMH_W-1:0] hv, lv;
  logic [TH_W-1:0]          hv_sat, lv_sat;

  always_comb begin
    hv = $signed(SUMH_W'(m_mean_q)) + $signed(SUMH_W'(m_up_q));
    lv = $signed(SUMH_W'(m_mean_q)) - $signed(SUMH_W'(m_dn_q));
    if (hv > TH_MAX)      hv_sat = TH_MAX[TH_W-1:0];
    else if (hv < TH_MIN) hv_sat = TH_MIN[TH_W-1:0];
    else                  hv_sat = hv[TH_W-1:0];
    if (lv > TH_MAX)      lv_sat = TH_MAX[TH_W-1:0];
    else if (lv < TH_MIN) lv_sat = TH_MIN[TH_W-1:0];
    else                  lv_sat = lv[TH_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i && m_bv_q) begin
      high_mem[m_addr_q] <= hv_sat;
      low_mem[m_addr_q]  <= lv_sat;
    end
  end

  assign in_range_o = ir_sh_q[DVD_W];

endmodule
`default_nettype wire

@@ rtl/core/abgseg_merge.sv @@
`default_nettype none
module abgseg_merge (
  input  wire logic                                valid_i,
  input  wire logic [1:0]                          func_i,
  input  wire logic                                ok_i,
  input  wire logic [abgseg_pkg::LANES-1:0]        in_range_i,
  output logic                                     result_valid_o,
  output logic [abgseg_pkg::MASK_W-1:0]            mask_o,
  output logic                                     mask_valid_o
);

  // any channel in range means background
  always_comb begin
    result_valid_o = valid_i;
    mask_o         = abgseg_pkg::MASK_BG;
    mask_valid_o   = 1'b0;
    if (func_i == abgseg_pkg::FUNC_SEGMENT) begin
      mask_valid_o = 1'b1;
      mask_o       = (ok_i && (|in_range_i)) ? abgseg_pkg::MASK_BG : abgseg_pkg::MASK_FG;
    end
  end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
  import abgseg_pkg::*;

  // item kind that the block has no use for: must answer background, not valid
  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam int NUM_MAX_FRAMES = 1024;
  localparam int NUM_MAX_PIXELS = 65536;
  // cycles with no handshake before giving up; covers the clearing pass after reset
  localparam int STALL_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]      func;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0] ch [LANES];
  } pix_item_t;

  typedef struct {
    logic [MASK_W-1:0] mask;
    logic              mvalid;
  } mask_res_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [1:0] func_i;
  logic [IDX_W-1:0] pixel_index_i;
  logic [CH_W-1:0] chan_a_i, chan_b_i, chan_c_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [MASK_W-1:0] mask_o;
  logic mask_valid_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  average_background_segmenter u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .pixel_index_i,
    .chan_a_i, .chan_b_i, .chan_c_i, .out_valid_o, .out_ready_i, .mask_o,
    .mask_valid_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // 2 ns clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // pending items, expected masks, and the current item on the input channel
  pix_item_t pending_q[$];
  mask_res_t mask_q[$];
  pix_item_t cur_item;

  // idle percentages per side, and the long receiver hold-off request
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;

  int n_items = 0;
  int n_results = 0;
  int n_fg = 0;
  int n_seg = 0;
  int n_errors = 0;
  int idle_cycles = 0;

  // shadow background model, sparse over pixel-lane address
  logic [SUM_W-1:0] acc_sum [int];
  logic [SUM_W-1:0] acc_dsum [int];
  logic [CH_W-1:0]  last_px [int];
  longint           th_high [int];
  longint           th_low [int];
  int  frames_done;
  bit  first_frame_seen;
  logic [CFG_W-1:0]   pix_per_frame;
  logic [SCALE_W-1:0] up_scale;
  logic [SCALE_W-1:0] dn_scale;

  // pixels used by the stimulus; together their indexes toggle every bit
  logic [IDX_W-1:0] pix_pool [8] = '{16'd0, 16'd1, 16'd2, 16'd3,
                                     16'd43690, 16'd21845, 16'd32768, 16'd65535};
  // per-pixel scene colour that learn frames jitter around
  logic [CH_W-1:0] scene [4][LANES];

  function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] a, int b);
    int s;
    s = int'(a) + b;
    return (s > (1 << SUM_W) - 1) ? SUM_W'((1 << SUM_W) - 1) : SUM_W'(s);
  endfunction

  function automatic longint th_sat(longint v);
    if (v > (64'sd1 << (TH_W - 1)) - 1) return (64'sd1 << (TH_W - 1)) - 1;
    if (v < -(64'sd1 << (TH_W - 1))) return -(64'sd1 << (TH_W - 1));
    return v;
  endfunction

  // advance the shadow model by one item and give the mask it must produce
  function automatic mask_res_t segment_predict(pix_item_t it);
    mask_res_t r;
    int eff;
    int adr;
    int d;
    bit acc;
    longint n, mean, diff, x;
    r.mask = MASK_BG;
    r.mvalid = 1'b0;
    if (it.func == FUNC_LEARN) begin
      eff = pix_per_frame;
      if (eff == 0) eff = 1;
      if (eff > NUM_MAX_PIXELS) eff = NUM_MAX_PIXELS;
      acc = first_frame_seen && frames_done < NUM_MAX_FRAMES;
      for (int c = 0; c < LANES; c++) begin
        adr = int'(it.idx) * LANES + c;
        if (acc) begin
          d = int'(it.ch[c]) - int'(last_px[adr]);
          if (d < 0) d = -d;
          acc_sum[adr] = sum_sat(acc_sum.exists(adr) ? acc_sum[adr] : '0, it.ch[c]);
          acc_dsum[adr] = sum_sat(acc_dsum.exists(adr) ? acc_dsum[adr] : '0, d);
        end
        last_px[adr] = it.ch[c];
      end
      // frame end: the first one only arms accumulation
      if (int'(it.idx) == eff - 1) begin
        if (first_frame_seen) begin
          if (frames_done < NUM_MAX_FRAMES) frames_done++;
        end else begin
          first_frame_seen = 1'b1;
        end
      end
    end else if (it.func == FUNC_BUILD) begin
      n = (frames_done == 0) ? 1 : frames_done;
      for (int c = 0; c < LANES; c++) begin
        adr = int'(it.idx) * LANES + c;
        mean = (longint'(acc_sum.exists(adr) ? acc_sum[adr] : '0) << 8) / n;
        diff = (longint'(acc_dsum.exists(adr) ? acc_dsum[adr] : '0) << 8) / n + 256;
        th_high[adr] = th_sat(mean + ((longint'(up_scale) * diff) >>> SCALE_FRAC));
        th_low[adr] = th_sat(mean - ((longint'(dn_scale) * diff) >>> SCALE_FRAC));
      end
    end else if (it.func == FUNC_SEGMENT) begin
      r.mvalid = 1'b1;
      r.mask = MASK_FG;
      // any channel in range marks background
      for (int c = 0; c < LANES; c++) begin
        adr = int'(it.idx) * LANES + c;
        x = longint'(it.ch[c]) << 8;
        if (th_low[adr] <= x && x < th_high[adr]) r.mask = MASK_BG;
      end
    end
    return r;
  endfunction

  // input driver: one item per handshake, valid held until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        mask_q.push_back(segment_predict(cur_item));
        n_items++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          cur_item = pending_q.pop_front();
          func_i <= cur_item.func;
          pixel_index_i <= cur_item.idx;
          chan_a_i <= cur_item.ch[0];
          chan_b_i <= cur_item.ch[1];
          chan_c_i <= cur_item.ch[2];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure and the long hold-off
  always @(posedge clk_i) begin
    mask_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (mask_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("[%0t] unexpected result mask=%0d valid=%0b", $realtime,
                     mask_o, mask_valid_o);
        end else begin
          want = mask_q.pop_front();
          if (want.mvalid) n_seg++;
          if (want.mvalid && want.mask == MASK_FG) n_fg++;
          if (mask_o !== want.mask || mask_valid_o !== want.mvalid) begin
            n_errors++;
            if (n_errors <= 10)
              $display("[%0t] mask mismatch: expected mask=%0d valid=%0b, got mask=%0d valid=%0b",
                       $realtime, want.mask, want.mvalid, mask_o, mask_valid_o);
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // register write; the shadow copy follows
  task automatic write_reg(logic [CFG_IDX_W-1:0] ridx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ridx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (ridx)
      CFG_PIXEL_COUNT: pix_per_frame = val;
      CFG_HI_SCALE: up_scale = val[SCALE_W-1:0];
      CFG_LOW_SCALE: dn_scale = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_pix(logic [1:0] f, logic [IDX_W-1:0] idx,
                          logic [CH_W-1:0] a, logic [CH_W-1:0] b, logic [CH_W-1:0] c);
    pix_item_t it;
    it.func = f;
    it.idx = idx;
    it.ch[0] = a;
    it.ch[1] = b;
    it.ch[2] = c;
    pending_q.push_back(it);
  endtask

  // sender pauses here until every expected result is back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() > 0 || in_valid_i || mask_q.size() > 0);
    repeat (5) @(posedge clk_i);
  endtask

  function automatic logic [CH_W-1:0] jitter(logic [CH_W-1:0] base);
    int v;
    v = int'(base) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CH_W'(v);
  endfunction

  // well-formed frames of learn items with scene-like content, builds and
  // segments of learned pixels, plus a share of arbitrary items
  task automatic queue_traffic(int n_target, int frame_len, int learn_pct);
    int cnt;
    int r;
    int p;
    cnt = 0;
    while (cnt < n_target) begin
      r = $urandom_range(0, 99);
      if (r < learn_pct) begin
        for (int i = 0; i < frame_len; i++)
          push_pix(FUNC_LEARN, pix_pool[i], jitter(scene[i][0]), jitter(scene[i][1]),
                   jitter(scene[i][2]));
        cnt += frame_len;
      end else if (r < learn_pct + (100 - learn_pct) / 4) begin
        for (int i = 0; i < frame_len; i++)
          push_pix(FUNC_BUILD, pix_pool[i], $urandom, $urandom, $urandom);
        cnt += frame_len;
      end else if (r < learn_pct + (100 - learn_pct) * 3 / 4) begin
        p = $urandom_range(0, frame_len - 1);
        if ($urandom_range(0, 1))
          push_pix(FUNC_SEGMENT, pix_pool[p], jitter(scene[p][0]), jitter(scene[p][1]),
                   jitter(scene[p][2]));
        else
          push_pix(FUNC_SEGMENT, pix_pool[p], $urandom, $urandom, $urandom);
        cnt++;
      end else begin
        // arbitrary kind, any pool pixel, any samples
        push_pix($urandom_range(0, 3), pix_pool[$urandom_range(0, 7)], $urandom,
                 $urandom, $urandom);
        cnt++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    func_i = FUNC_LEARN;
    pixel_index_i = '0;
    chan_a_i = '0;
    chan_b_i = '0;
    chan_c_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PIXEL_COUNT;
    cfg_data_i = '0;
    frames_done = 0;
    first_frame_seen = 1'b0;
    pix_per_frame = PIXEL_COUNT_RST;
    up_scale = HI_SCALE_RST;
    dn_scale = LOW_SCALE_RST;
    for (int i = 0; i < 4; i++)
      for (int c = 0; c < LANES; c++) scene[i][c] = $urandom;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config, frame of 65536 so only the last pool pixel ends it
    snd_idle_pct = 38;
    rcv_idle_pct = 87;
    push_pix(FUNC_LEARN, pix_pool[0], 8'd0, 8'd0, 8'd0);
    push_pix(FUNC_LEARN, pix_pool[1], 8'd255, 8'd255, 8'd255);
    for (int i = 2; i < 8; i++) push_pix(FUNC_LEARN, pix_pool[i], $urandom, $urandom, $urandom);
    // build with no accumulated frame divides by one; build samples are ignored
    push_pix(FUNC_BUILD, pix_pool[0], 8'd255, 8'd0, 8'd255);
    for (int i = 1; i < 8; i++) push_pix(FUNC_BUILD, pix_pool[i], $urandom, $urandom, $urandom);
    // thresholds are [-6.0, 7.0): probe in range, out of range and the upper edge
    push_pix(FUNC_SEGMENT, pix_pool[0], 8'd0, 8'd0, 8'd0);
    push_pix(FUNC_SEGMENT, pix_pool[0], 8'd255, 8'd255, 8'd255);
    push_pix(FUNC_SEGMENT, pix_pool[1], 8'd7, 8'd7, 8'd6);
    push_pix(FUNC_SEGMENT, pix_pool[1], 8'd7, 8'd7, 8'd7);
    push_pix(FUNC_UNKNOWN, pix_pool[7], 8'd255, 8'd255, 8'd255);
    push_pix(FUNC_UNKNOWN, pix_pool[0], 8'd0, 8'd0, 8'd0);
    wait_idle();

    // four-pixel frames, random scales
    write_reg(CFG_PIXEL_COUNT, 17'd4);
    write_reg(CFG_HI_SCALE, $urandom);
    write_reg(CFG_LOW_SCALE, $urandom);
    queue_traffic(200, 4, 50);
    wait_idle();

    // pixel count zero acts as one; scale extremes
    snd_idle_pct = 87;
    rcv_idle_pct = 38;
    write_reg(CFG_PIXEL_COUNT, 17'd0);
    write_reg(CFG_HI_SCALE, 17'd0);
    write_reg(CFG_LOW_SCALE, 17'd255);
    queue_traffic(150, 1, 50);
    wait_idle();

    // oversized pixel count clamps to the maximum frame
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(CFG_PIXEL_COUNT, 17'h1FFFF);
    write_reg(CFG_HI_SCALE, 17'd255);
    write_reg(CFG_LOW_SCALE, 17'd0);
    queue_traffic(100, 4, 40);
    wait_idle();

    // three-pixel frames with a long receiver stall while items keep coming
    snd_idle_pct = 38;
    rcv_idle_pct = 87;
    write_reg(CFG_PIXEL_COUNT, 17'd3);
    write_reg(CFG_HI_SCALE, $urandom);
    write_reg(CFG_LOW_SCALE, $urandom);
    queue_traffic(200, 3, 50);
    @(negedge clk_i);
    snd_idle_pct = 0;
    hold_req = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    snd_idle_pct = 38;
    wait_idle();

    // one-pixel frames, mostly learning, drives the frame count into saturation
    snd_idle_pct = 87;
    rcv_idle_pct = 38;
    write_reg(CFG_PIXEL_COUNT, 17'd1);
    write_reg(CFG_HI_SCALE, HI_SCALE_RST);
    write_reg(CFG_LOW_SCALE, LOW_SCALE_RST);
    queue_traffic(575, 1, 94);
    wait_idle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(CFG_HI_SCALE, $urandom);
    queue_traffic(575, 1, 94);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d items, %0d results, %0d segment answers (%0d foreground)",
             n_items, n_results, n_seg, n_fg);
    $display("frames accumulated %0d, mismatches %0d, left over %0d",
             frames_done, n_errors, mask_q.size());
    if (n_errors == 0 && mask_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/abgseg_pkg.sv
rtl/core/abgseg_div.sv
rtl/core/abgseg_lane.sv
rtl/core/abgseg_merge.sv
rtl/core/average_background_segmenter.sv
test/tb_top.sv
